// ===== design/hard_disk_event_chain_unit_macros.svh =====
// Assertion macros for the hard disk event chain unit
`ifndef HARD_DISK_EVENT_CHAIN_UNIT_MACROS_SVH
`define HARD_DISK_EVENT_CHAIN_UNIT_MACROS_SVH
`ifndef SYNTH
`define HDEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HDEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HDEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/hdec_pkg.sv =====
// ----------------------------------------------------------------------------
// hdec_pkg
// Shared types and constants for the hard disk event chain unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hdec_pkg;
  localparam int NumParticles = 256;
  localparam int CoordBits    = 24;
  localparam int MaxEvents    = 1024;
  localparam int IdxBits      = $clog2(NumParticles);
  localparam int CntBits      = $clog2(MaxEvents + 1);
  localparam int RadBits      = 22;
  localparam int SqBits       = 2 * (RadBits + 1);   // (2r)^2 width
  localparam int RootBits     = RadBits + 1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0]   idx_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_CHAIN = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT, ST_RD_OUT, ST_CUR_RD, ST_CUR_WAIT, ST_SCAN_RD,
    ST_SCAN_WAIT, ST_PERP, ST_SQ_GO, ST_SQRT, ST_FLIGHT, ST_MOVE, ST_FIN_RD,
    ST_FIN_WAIT, ST_FIN_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SqBits-1:0]   value;
  } sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [RootBits-1:0] root;
  } sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== design/hard_disk_event_chain_unit.sv =====
// ----------------------------------------------------------------------------
// hard_disk_event_chain_unit
// Event chain Monte Carlo of hard disks on a periodic unit square.
// ----------------------------------------------------------------------------
// A load shows its result word in the cycle after start; a read's word follows ST_RD_WAIT and ST_RD_OUT.
// Chain: each event reads the mover, scans all NUM_PARTICLES disks and runs the serial
//   square root on each close pair; up to MAX_EVENTS events, then the final read-out.
// One item at a time; busy drops in the cycle the result word shows, a load never raises it.
// Reset (rst_n low, synchronous) idles the sequencer, restores disk_radius.
// The receiver cannot stall: each result word is valid for one cycle only.
`default_nettype none
`include "hard_disk_event_chain_unit_macros.svh"
module hard_disk_event_chain_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [7:0]                        in_particle_index,
  input  wire logic [23:0]                       in_coord_x,
  input  wire logic [23:0]                       in_coord_y,
  input  wire logic                              in_direction,
  input  wire logic                              cfg_we,
  input  wire logic [21:0]                       cfg_disk_radius,
  output logic                                   out_valid,
  output logic [7:0]                             out_result_index,
  output logic [23:0]                            out_result_x,
  output logic [23:0]                            out_result_y,
  output logic [10:0]                            out_event_count,
  output logic                                   out_chain_truncated
);
  import hdec_pkg::*;

  localparam int DistBits = CoordBits + 1;

  state_t state_r, state_nxt;

  logic [RadBits-1:0]  radius_r;
  kind_t               kind_r;
  idx_t                cur_r, cur_nxt;
  idx_t                scan_r, scan_nxt;
  idx_t                next_r, next_nxt;
  logic [7:0]          oidx_r;
  logic                dir_r;
  logic                inrange_r;
  coord_t              ldx_r, ldy_r;
  coord_t              curx_r, cury_r;     // mover position
  coord_t              ox_r, oy_r;         // scanned disk
  logic [DistBits-1:0] togo_r, togo_nxt;
  logic [DistBits-1:0] best_r, best_nxt;
  logic [CntBits-1:0]  cnt_r, cnt_nxt;
  logic [RootBits-1:0] perp_r;
  logic [DistBits-1:0] remain_r;
  idx_t                lifted_r;

  // Memory ports
  logic   ram_we;
  idx_t   ram_addr;
  coord_t ram_wx, ram_wy, ram_rx, ram_ry;

  hdec_ram #(.Width(CoordBits), .Depth(NumParticles)) u_xram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wx), .rdata(ram_rx));
  hdec_ram #(.Width(CoordBits), .Depth(NumParticles)) u_yram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wy), .rdata(ram_ry));

  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;
  hdec_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  // Perpendicular periodic separation: min(diff, 1 - diff).
  coord_t              diff;
  logic [CoordBits:0]  alt;
  logic [CoordBits:0]  dperp;
  logic [RadBits:0]    two_r;
  logic                close;
  always_comb begin
    diff  = dir_r ? (oy_r - cury_r) : (ox_r - curx_r);
    alt   = {1'b1, {CoordBits{1'b0}}} - {1'b0, diff};
    dperp = ({1'b0, diff} < alt) ? {1'b0, diff} : alt;
    two_r = {radius_r, 1'b0};
    close = dperp <= {{(CoordBits-RadBits){1'b0}}, two_r};
  end

  // Square radicand from the registered perpendicular distance.
  logic [SqBits-1:0] sq_two_r, sq_perp, radicand;
  always_comb begin
    sq_two_r = SqBits'(two_r) * SqBits'(two_r);
    sq_perp  = SqBits'(perp_r) * SqBits'(perp_r);
    radicand = sq_two_r - sq_perp;
  end

  // Free flight from mover to scanned disk.
  coord_t flight;
  always_comb begin
    flight = dir_r ? (ox_r - curx_r - CoordBits'(sq_rsp.root))
                   : (oy_r - cury_r - CoordBits'(sq_rsp.root));
  end

  logic accept;
  logic idx_ok;
  assign accept = start && !busy;
  assign idx_ok = {1'b0, in_particle_index} < 9'(NumParticles);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_CHAIN && idx_ok) state_nxt = ST_CUR_RD;
          else if (in_kind != KIND_LOAD) state_nxt = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT:   state_nxt = ST_RD_OUT;
      ST_RD_OUT:    state_nxt = ST_IDLE;
      ST_CUR_RD:    state_nxt = ST_CUR_WAIT;
      ST_CUR_WAIT: begin
        if (togo_r == '0 || cnt_r == CntBits'(MaxEvents)) state_nxt = ST_FIN_RD;
        else state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD:   state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_nxt = ST_PERP;
      ST_PERP: begin
        if (scan_r != cur_r && close) state_nxt = ST_SQ_GO;
        else if (scan_r == idx_t'(NumParticles-1)) state_nxt = ST_MOVE;
        else state_nxt = ST_SCAN_RD;
      end
      ST_SQ_GO:     state_nxt = ST_SQRT;
      ST_SQRT:      if (sq_rsp.done) state_nxt = ST_FLIGHT;
      ST_FLIGHT: begin
        if (scan_r == idx_t'(NumParticles-1)) state_nxt = ST_MOVE;
        else state_nxt = ST_SCAN_RD;
      end
      ST_MOVE:      state_nxt = ST_CUR_RD;
      ST_FIN_RD:    state_nxt = ST_FIN_WAIT;
      ST_FIN_WAIT:  state_nxt = ST_FIN_OUT;
      ST_FIN_OUT:   state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = cur_r;
    ram_wx   = ldx_r;
    ram_wy   = ldy_r;
    sq_req   = '0;
    cur_nxt  = cur_r;
    scan_nxt = scan_r;
    next_nxt = next_r;
    togo_nxt = togo_r;
    best_nxt = best_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        ram_addr = in_particle_index[IdxBits-1:0];
        ram_wx   = in_coord_x;
        ram_wy   = in_coord_y;
        ram_we   = accept && in_kind == KIND_LOAD && idx_ok;
        cur_nxt  = in_particle_index[IdxBits-1:0];
        togo_nxt = DistBits'(5 * {3'b0, radius_r});
        cnt_nxt  = '0;
      end
      ST_CUR_RD: ram_addr = cur_r;
      ST_CUR_WAIT: begin
        scan_nxt = '0;
        best_nxt = togo_r;
        next_nxt = cur_r;
      end
      ST_SCAN_RD: ram_addr = scan_r;
      ST_PERP: begin
        if (!(scan_r != cur_r && close)) scan_nxt = scan_r + idx_t'(1);
      end
      // Launch the root once perp_r holds this pair's distance.
      ST_SQ_GO: sq_req.start = 1'b1;
      ST_FLIGHT: begin
        if ({1'b0, flight} < best_r) begin
          best_nxt = {1'b0, flight};
          next_nxt = scan_r;
        end
        scan_nxt = scan_r + idx_t'(1);
      end
      ST_MOVE: begin
        ram_we   = 1'b1;
        ram_addr = cur_r;
        ram_wx   = dir_r ? curx_r + best_r[CoordBits-1:0] : curx_r;
        ram_wy   = dir_r ? cury_r : cury_r + best_r[CoordBits-1:0];
        togo_nxt = togo_r - best_r;
        if (next_r != cur_r) begin
          cnt_nxt = cnt_r + CntBits'(1);
          cur_nxt = next_r;
        end
      end
      ST_FIN_RD: ram_addr = cur_r;
      ST_RD_WAIT, ST_RD_OUT, ST_SCAN_WAIT, ST_SQRT, ST_FIN_WAIT, ST_FIN_OUT: begin
        ram_addr = cur_r;
      end
      default: ram_addr = cur_r;
    endcase
    sq_req.value = radicand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radius_r  <= RadBits'(167772);
      remain_r  <= '0;
      lifted_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) radius_r <= cfg_disk_radius;
      out_valid <= (accept && in_kind == KIND_LOAD) ||
                   state_r == ST_RD_OUT || state_r == ST_FIN_OUT;
      if (state_r == ST_FIN_RD) begin
        remain_r <= togo_r;
        lifted_r <= cur_r;
      end
    end
    cur_r  <= cur_nxt;
    scan_r <= scan_nxt;
    next_r <= next_nxt;
    togo_r <= togo_nxt;
    best_r <= best_nxt;
    cnt_r  <= cnt_nxt;
    if (accept) begin
      kind_r    <= kind_t'(in_kind);
      oidx_r    <= in_particle_index;
      dir_r     <= in_direction;
      inrange_r <= idx_ok;
      ldx_r     <= in_coord_x;
      ldy_r     <= in_coord_y;
    end
    if (state_r == ST_CUR_WAIT) begin
      curx_r <= ram_rx;
      cury_r <= ram_ry;
    end
    if (state_r == ST_SCAN_WAIT) begin
      ox_r <= ram_rx;
      oy_r <= ram_ry;
    end
    if (state_r == ST_PERP) perp_r <= dperp[RootBits-1:0];
  end

  // Result word
  logic [7:0]  res_idx_r;
  coord_t      res_x_r, res_y_r;
  logic [10:0] res_cnt_r;
  logic        res_tr_r;
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_LOAD) begin
      res_idx_r <= in_particle_index;
      res_x_r   <= idx_ok ? in_coord_x : '0;
      res_y_r   <= idx_ok ? in_coord_y : '0;
      res_cnt_r <= '0;
      res_tr_r  <= 1'b0;
    end else if (state_r == ST_RD_OUT) begin
      res_idx_r <= (kind_r == KIND_NONE) ? 8'd0 : oidx_r;
      res_x_r   <= (kind_r == KIND_READ && inrange_r) ? ram_rx : '0;
      res_y_r   <= (kind_r == KIND_READ && inrange_r) ? ram_ry : '0;
      res_cnt_r <= '0;
      res_tr_r  <= 1'b0;
    end else if (state_r == ST_FIN_OUT) begin
      res_idx_r <= 8'(cur_r);
      res_x_r   <= ram_rx;
      res_y_r   <= ram_ry;
      res_cnt_r <= 11'(cnt_r);
      res_tr_r  <= togo_r != '0;
    end
  end

  assign busy                = state_r != ST_IDLE;
  assign out_result_index    = res_idx_r;
  assign out_result_x        = res_x_r;
  assign out_result_y        = res_y_r;
  assign out_event_count     = res_cnt_r;
  assign out_chain_truncated = res_tr_r;

  logic unused;
  assign unused = ^{remain_r, lifted_r};

  `HDEC_ASSERT_IMPL(a_cnt_limit, clk, rst_n, busy, cnt_r <= CntBits'(MaxEvents))
  `HDEC_ASSERT_NEXT(a_fin_valid, clk, rst_n, state_r == ST_FIN_OUT, out_valid)
  `HDEC_ASSERT_IMPL(a_move_togo, clk, rst_n, state_r == ST_MOVE, best_r <= togo_r)
endmodule
`default_nettype wire

// ===== design/hdec_ram.sv =====
// ----------------------------------------------------------------------------
// hdec_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module hdec_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/hdec_sqrt.sv =====
// ----------------------------------------------------------------------------
// hdec_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hard_disk_event_chain_unit_macros.svh"
module hdec_sqrt (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hdec_pkg::sqrt_req_t req,
  output hdec_pkg::sqrt_rsp_t   rsp
);
  import hdec_pkg::*;
  localparam int StepBits = $clog2(RootBits + 1);

  logic [SqBits-1:0]   rem_r, rem_nxt;
  logic [RootBits-1:0] root_r, root_nxt;
  logic [StepBits-1:0] step_r, step_nxt;
  logic                busy_r, busy_nxt;

  // Sequencer: load the radicand on start, then count down one step per bit.
  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (req.start) begin
      rem_nxt  = req.value;
      root_nxt = '0;
      step_nxt = StepBits'(RootBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      busy_nxt = (step_r != StepBits'(1));
      step_nxt = step_r - StepBits'(1);
    end
  end

  // Separate datapath: partial remainder in acc_r, radicand shifted out of rem_r.
  logic [RootBits+1:0] acc_r, acc_nxt;
  logic [RootBits+1:0] cand;
  logic [RootBits+1:0] shifted;
  always_comb begin
    shifted = {acc_r[RootBits-1:0], rem_r[SqBits-1 -: 2]};
    cand    = {root_r, 2'b01};
    acc_nxt = acc_r;
    if (req.start) begin
      acc_nxt = '0;
    end else if (busy_r) begin
      if (shifted >= cand) acc_nxt = shifted - cand;
      else acc_nxt = shifted;
    end
  end

  logic [SqBits-1:0]   rsh_nxt;
  logic [RootBits-1:0] rt_nxt;
  always_comb begin
    rsh_nxt = rem_nxt;
    rt_nxt  = root_nxt;
    if (!req.start && busy_r) begin
      rsh_nxt = {rem_r[SqBits-3:0], 2'b00};
      rt_nxt  = {root_r[RootBits-2:0], (shifted >= cand)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rsh_nxt;
    root_r <= rt_nxt;
    acc_r  <= acc_nxt;
  end

  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= busy_r && !req.start && (step_r == StepBits'(1));
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  `HDEC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `HDEC_ASSERT_IMPL(a_step_range, clk, rst_n, busy_r, step_r != '0)
  `HDEC_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_r)
endmodule
`default_nettype wire
